FILE: hdl/mdb_pkg.sv
package mdb_pkg;

    // Frame geometry
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int MIN_DIM    = 4;
    localparam int DIM_W      = 12;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int RING_ROWS  = 8;
    localparam int SLOT_W     = $clog2(RING_ROWS);
    localparam int PIX_W      = 24;
    localparam int TAPS       = 7;
    localparam int MID        = 3;

    // Configuration port
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_FINE_GAIN    = 2'd2,
        REG_COARSE_GAIN  = 2'd3
    } reg_idx_t;

    localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = DIM_W'(640);
    localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = DIM_W'(480);
    localparam logic [7:0]       RST_FINE_GAIN    = 8'd24;
    localparam logic [7:0]       RST_COARSE_GAIN  = 8'd32;

    // Kernel weights, Q0.COEFF_BITS, rounded from Q0.30
    localparam int COEFF_BITS = 16;
    localparam longint unsigned HALF_Q30 = 64'd1 << (29 - COEFF_BITS);
    localparam int Q30_SH = 30 - COEFF_BITS;
    localparam logic [COEFF_BITS-1:0] W3_D1 =
        COEFF_BITS'((64'd294278940 + HALF_Q30) >> Q30_SH);
    localparam logic [COEFF_BITS-1:0] W3_C =
        COEFF_BITS'((64'd1 << COEFF_BITS) - 2 * ((64'd294278940 + HALF_Q30) >> Q30_SH));
    localparam longint unsigned W7_D1_L = (64'd204776330 + HALF_Q30) >> Q30_SH;
    localparam longint unsigned W7_D2_L = (64'd140740580 + HALF_Q30) >> Q30_SH;
    localparam longint unsigned W7_D3_L = (64'd75333008 + HALF_Q30) >> Q30_SH;
    localparam logic [COEFF_BITS-1:0] W7_D1 = COEFF_BITS'(W7_D1_L);
    localparam logic [COEFF_BITS-1:0] W7_D2 = COEFF_BITS'(W7_D2_L);
    localparam logic [COEFF_BITS-1:0] W7_D3 = COEFF_BITS'(W7_D3_L);
    localparam logic [COEFF_BITS-1:0] W7_C =
        COEFF_BITS'((64'd1 << COEFF_BITS) - 2 * (W7_D1_L + W7_D2_L + W7_D3_L));

    // Datapath widths
    localparam int HSUM_W = 8 + COEFF_BITS;
    localparam int VSUM_W = 8 + 2 * COEFF_BITS;
    localparam int BLUR_W = 8 + COEFF_BITS;
    localparam int DIFF_W = COEFF_BITS + 10;
    localparam int PROD_W = COEFF_BITS + 19;
    localparam int T_W    = COEFF_BITS + 21;

    typedef logic [PIX_W-1:0] pix_t;
    typedef pix_t [TAPS-1:0] col_t;
    typedef col_t [TAPS-1:0] win_t;

    typedef struct packed {
        logic valid;
        logic done;
    } mdb_ctrl_t;

    // Saturate a position or distance to 3 (window radius)
    function automatic logic [1:0] sat3(input logic [DIM_W-1:0] v);
        return (v > DIM_W'(3)) ? 2'd3 : v[1:0];
    endfunction

    // Reflect-101 tap selection inside a 7-wide raw window.
    // lo/hi: distance to the first/last valid sample, saturated to 3.
    function automatic logic [2:0] mirror_tap(input int tap, input logic [1:0] lo,
                                              input logic [1:0] hi);
        int d;
        int m;
        d = tap - MID;
        m = tap;
        if (d < -int'(lo))
            m = MID - 2 * int'(lo) - d;
        else if (d > int'(hi))
            m = MID + 2 * int'(hi) - d;
        return 3'(m);
    endfunction

    function automatic logic [COEFF_BITS-1:0] w7_tap(input int i);
        logic [COEFF_BITS-1:0] w;
        w = W7_C;
        if (i == 0 || i == 6)
            w = W7_D3;
        else if (i == 1 || i == 5)
            w = W7_D2;
        else if (i == 2 || i == 4)
            w = W7_D1;
        return w;
    endfunction

    function automatic logic [COEFF_BITS-1:0] w3_tap(input int i);
        return (i == 1) ? W3_C : W3_D1;
    endfunction

endpackage

FILE: hdl/mdb_ram.sv
module mdb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/mdb_kernel.sv
module mdb_kernel (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  mdb_pkg::mdb_ctrl_t ctrl_in,
    input  mdb_pkg::win_t      win,
    input  logic [7:0]         fine_gain,
    input  logic [7:0]         coarse_gain,
    output mdb_pkg::mdb_ctrl_t ctrl_out,
    output logic [7:0]         blue,
    output logic [7:0]         green,
    output logic [7:0]         red
);

    localparam int B = mdb_pkg::COEFF_BITS;
    localparam logic [mdb_pkg::VSUM_W-1:0] ROUND_V = mdb_pkg::VSUM_W'(1) << (B - 1);
    localparam logic [mdb_pkg::T_W-1:0] ROUND_T = mdb_pkg::T_W'(1) << (B + 3);

    mdb_pkg::mdb_ctrl_t c3_reg, c4_reg, c5_reg;

    logic [mdb_pkg::HSUM_W-1:0] h7_reg  [3][7];
    logic [mdb_pkg::HSUM_W-1:0] h7_next [3][7];
    logic [mdb_pkg::HSUM_W-1:0] h3_reg  [3][3];
    logic [mdb_pkg::HSUM_W-1:0] h3_next [3][3];
    logic [7:0] x3_reg [3];
    logic [7:0] x4_reg [3];
    logic [7:0] x5_reg [3];

    logic [mdb_pkg::BLUR_W-1:0] b3_reg  [3];
    logic [mdb_pkg::BLUR_W-1:0] b3_next [3];
    logic [mdb_pkg::BLUR_W-1:0] b7_reg  [3];
    logic [mdb_pkg::BLUR_W-1:0] b7_next [3];

    logic signed [mdb_pkg::PROD_W-1:0] pf_reg  [3];
    logic signed [mdb_pkg::PROD_W-1:0] pf_next [3];
    logic signed [mdb_pkg::PROD_W-1:0] pc_reg  [3];
    logic signed [mdb_pkg::PROD_W-1:0] pc_next [3];

    logic [7:0] res [3];

    logic [8:0]                 s_pair [4];
    logic [mdb_pkg::HSUM_W:0]   h_acc;
    logic [mdb_pkg::VSUM_W-1:0] v7_acc, v3_acc;
    logic signed [mdb_pkg::DIFF_W-1:0] d_fine, d_coarse;
    logic signed [mdb_pkg::PROD_W-1:0] g_f, g_c, d_fx, d_cx;
    logic signed [mdb_pkg::T_W-1:0]    t_sum;
    logic [mdb_pkg::T_W-B-5:0]         t_int;

    // Horizontal pass: symmetric pairs times constant weights
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            for (int i = 0; i < 7; i++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    s_pair[k] = {1'b0, win[i][k][8*ch +: 8]} + {1'b0, win[i][6-k][8*ch +: 8]};
                end
                s_pair[3] = {1'b0, win[i][3][8*ch +: 8]};
                h_acc = (mdb_pkg::HSUM_W+1)'(mdb_pkg::W7_D3) * (mdb_pkg::HSUM_W+1)'(s_pair[0])
                      + (mdb_pkg::HSUM_W+1)'(mdb_pkg::W7_D2) * (mdb_pkg::HSUM_W+1)'(s_pair[1])
                      + (mdb_pkg::HSUM_W+1)'(mdb_pkg::W7_D1) * (mdb_pkg::HSUM_W+1)'(s_pair[2])
                      + (mdb_pkg::HSUM_W+1)'(mdb_pkg::W7_C) * (mdb_pkg::HSUM_W+1)'(s_pair[3]);
                h7_next[ch][i] = mdb_pkg::HSUM_W'(h_acc);
            end
            for (int i = 0; i < 3; i++)
            begin
                s_pair[0] = {1'b0, win[i+2][2][8*ch +: 8]} + {1'b0, win[i+2][4][8*ch +: 8]};
                s_pair[1] = {1'b0, win[i+2][3][8*ch +: 8]};
                h_acc = (mdb_pkg::HSUM_W+1)'(mdb_pkg::W3_D1) * (mdb_pkg::HSUM_W+1)'(s_pair[0])
                      + (mdb_pkg::HSUM_W+1)'(mdb_pkg::W3_C) * (mdb_pkg::HSUM_W+1)'(s_pair[1]);
                h3_next[ch][i] = mdb_pkg::HSUM_W'(h_acc);
            end
        end
    end

    // Vertical pass and rounding to COEFF_BITS fractional bits
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            v7_acc = ROUND_V;
            for (int i = 0; i < 7; i++)
            begin
                v7_acc = v7_acc + mdb_pkg::VSUM_W'(mdb_pkg::w7_tap(i))
                                * mdb_pkg::VSUM_W'(h7_reg[ch][i]);
            end
            v3_acc = ROUND_V;
            for (int i = 0; i < 3; i++)
            begin
                v3_acc = v3_acc + mdb_pkg::VSUM_W'(mdb_pkg::w3_tap(i))
                                * mdb_pkg::VSUM_W'(h3_reg[ch][i]);
            end
            b7_next[ch] = mdb_pkg::BLUR_W'(v7_acc >> B);
            b3_next[ch] = mdb_pkg::BLUR_W'(v3_acc >> B);
        end
    end

    // Detail terms times gains
    always_comb
    begin
        g_f = mdb_pkg::PROD_W'($signed({1'b0, fine_gain}));
        g_c = mdb_pkg::PROD_W'($signed({1'b0, coarse_gain}));
        for (int ch = 0; ch < 3; ch++)
        begin
            d_fine   = $signed(mdb_pkg::DIFF_W'({x4_reg[ch], {B{1'b0}}}))
                     - $signed(mdb_pkg::DIFF_W'(b3_reg[ch]));
            d_coarse = $signed(mdb_pkg::DIFF_W'(b3_reg[ch]))
                     - $signed(mdb_pkg::DIFF_W'(b7_reg[ch]));
            d_fx = mdb_pkg::PROD_W'(d_fine);
            d_cx = mdb_pkg::PROD_W'(d_coarse);
            pf_next[ch] = g_f * d_fx;
            pc_next[ch] = g_c * d_cx;
        end
    end

    // Final sum, round half up, clamp to 0..255
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            t_sum = $signed(mdb_pkg::T_W'({x5_reg[ch], {(B + 4){1'b0}}}))
                  + mdb_pkg::T_W'(pf_reg[ch]) + mdb_pkg::T_W'(pc_reg[ch])
                  + $signed(ROUND_T);
            t_int = t_sum[mdb_pkg::T_W-1:B+4];
            if (t_sum <= 0)
                res[ch] = 8'd0;
            else if (t_int > (mdb_pkg::T_W-B-4)'(255))
                res[ch] = 8'd255;
            else
                res[ch] = t_int[7:0];
        end
    end

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c3_reg <= '0;
            c4_reg <= '0;
            c5_reg <= '0;
        end
        else if (adv)
        begin
            c3_reg <= ctrl_in;
            c4_reg <= c3_reg;
            c5_reg <= c4_reg;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h7_reg <= h7_next;
            h3_reg <= h3_next;
            b3_reg <= b3_next;
            b7_reg <= b7_next;
            pf_reg <= pf_next;
            pc_reg <= pc_next;
            for (int ch = 0; ch < 3; ch++)
            begin
                x3_reg[ch] <= win[3][3][8*ch +: 8];
            end
            x4_reg <= x3_reg;
            x5_reg <= x4_reg;
        end
    end

    assign ctrl_out = c5_reg;
    assign blue     = res[0];
    assign green    = res[1];
    assign red      = res[2];

endmodule

FILE: hdl/multiscale_detail_boost_filter_top.sv
// A result passes the stage 1, window, kernel and result registers before result_valid;
// a pixel's result appears with the request 3 lines + 3 pixels later.
// Throughput: one request per cycle unless a held result drops pixel_ready; set by the
// eight line RAMs (one write and one read port each) feeding a 7-column sliding window.
// Reset (rst_n, async, active low) clears positions, pipeline valids and registers to
// their defaults; the line RAMs are not cleared (each entry is written before use).
module multiscale_detail_boost_filter_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        pixel_valid,
    output logic                        pixel_ready,
    input  logic                        operation,
    input  logic [7:0]                  blue_in,
    input  logic [7:0]                  green_in,
    input  logic [7:0]                  red_in,
    output logic                        result_valid,
    input  logic                        result_ready,
    output logic [7:0]                  blue_out,
    output logic [7:0]                  green_out,
    output logic [7:0]                  red_out,
    output logic                        frame_done,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mdb_pkg::PADDR_W-1:0] paddr,
    input  logic [mdb_pkg::PDATA_W-1:0] pwdata,
    output logic [mdb_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    // Configuration registers
    logic [mdb_pkg::DIM_W-1:0] frame_width_reg, frame_height_reg;
    logic [7:0]                fine_gain_reg, coarse_gain_reg;
    logic [mdb_pkg::DIM_W-1:0] eff_w, eff_h;
    logic [mdb_pkg::COL_W-1:0] w_m1;
    logic [mdb_pkg::ROW_W-1:0] h_m1;
    logic                      cfg_wr, geom_wr;
    mdb_pkg::reg_idx_t         cfg_idx;

    // Positions
    logic [mdb_pkg::COL_W-1:0] in_col_reg, in_col_next;
    logic [mdb_pkg::ROW_W-1:0] in_row_reg, in_row_next;
    logic [mdb_pkg::COL_W-1:0] out_col_reg, out_col_next, out_col_inc;
    logic [mdb_pkg::ROW_W-1:0] out_row_reg, out_row_next, out_row_inc;
    logic [mdb_pkg::COL_W-1:0] fetch_col_reg, fetch_col_next, fetch_col;
    logic [mdb_pkg::ROW_W:0]   fetch_row_reg, fetch_row_next, fetch_row;
    logic                      draining, accept, shift, emit, out_last;

    // Stage 1
    logic                       s1_valid_reg, s1_emit_reg, s1_done_reg;
    logic [mdb_pkg::SLOT_W-1:0] s1_slot_reg;
    mdb_pkg::pix_t              s1_pix_reg;
    logic [1:0]                 s1_cl_reg, s1_cr_reg, s1_rl_reg, s1_rr_reg;
    mdb_pkg::pix_t              ram_rd [mdb_pkg::RING_ROWS];
    mdb_pkg::col_t              new_col;
    mdb_pkg::win_t              line_reg, new_line, win_reg, win_next;
    mdb_pkg::mdb_ctrl_t         c2_reg, k_out;

    // Result register
    logic                       result_valid_reg, frame_done_reg;
    logic [7:0]                 blue_reg, green_reg, red_reg;
    logic [7:0]                 k_blue, k_green, k_red;
    logic                       adv;

    // Effective geometry
    assign eff_w = (frame_width_reg < mdb_pkg::DIM_W'(mdb_pkg::MIN_DIM))
                 ? mdb_pkg::DIM_W'(mdb_pkg::MIN_DIM)
                 : (frame_width_reg > mdb_pkg::DIM_W'(mdb_pkg::MAX_WIDTH))
                 ? mdb_pkg::DIM_W'(mdb_pkg::MAX_WIDTH) : frame_width_reg;
    assign eff_h = (frame_height_reg < mdb_pkg::DIM_W'(mdb_pkg::MIN_DIM))
                 ? mdb_pkg::DIM_W'(mdb_pkg::MIN_DIM)
                 : (frame_height_reg > mdb_pkg::DIM_W'(mdb_pkg::MAX_HEIGHT))
                 ? mdb_pkg::DIM_W'(mdb_pkg::MAX_HEIGHT) : frame_height_reg;
    assign w_m1 = mdb_pkg::COL_W'(eff_w - 1'b1);
    assign h_m1 = mdb_pkg::ROW_W'(eff_h - 1'b1);

    // APB port
    assign pready  = 1'b1;
    assign cfg_idx = mdb_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel & penable & pwrite;
    assign geom_wr = cfg_wr & ((cfg_idx == mdb_pkg::REG_FRAME_WIDTH) ||
                               (cfg_idx == mdb_pkg::REG_FRAME_HEIGHT));

    always_comb
    begin
        unique case (cfg_idx)
            mdb_pkg::REG_FRAME_WIDTH:  prdata = mdb_pkg::PDATA_W'(frame_width_reg);
            mdb_pkg::REG_FRAME_HEIGHT: prdata = mdb_pkg::PDATA_W'(frame_height_reg);
            mdb_pkg::REG_FINE_GAIN:    prdata = mdb_pkg::PDATA_W'(fine_gain_reg);
            mdb_pkg::REG_COARSE_GAIN:  prdata = mdb_pkg::PDATA_W'(coarse_gain_reg);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= mdb_pkg::RST_FRAME_WIDTH;
            frame_height_reg <= mdb_pkg::RST_FRAME_HEIGHT;
            fine_gain_reg    <= mdb_pkg::RST_FINE_GAIN;
            coarse_gain_reg  <= mdb_pkg::RST_COARSE_GAIN;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                mdb_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[mdb_pkg::DIM_W-1:0];
                mdb_pkg::REG_FRAME_HEIGHT: frame_height_reg <= pwdata[mdb_pkg::DIM_W-1:0];
                mdb_pkg::REG_FINE_GAIN:    fine_gain_reg    <= pwdata[7:0];
                mdb_pkg::REG_COARSE_GAIN:  coarse_gain_reg  <= pwdata[7:0];
                default:                   ;
            endcase
        end
    end

    // Request decode
    assign adv         = !(result_valid_reg && !result_ready && k_out.valid);
    assign pixel_ready = adv;
    assign accept      = pixel_valid & pixel_ready;
    assign draining    = (in_col_reg == '0) && (in_row_reg == '0) &&
                         ((out_col_reg != '0) || (out_row_reg != '0));
    assign shift       = accept & (!operation | draining);
    assign emit        = operation ? draining
                       : ((in_row_reg > mdb_pkg::ROW_W'(3)) ||
                          ((in_row_reg == mdb_pkg::ROW_W'(3)) &&
                           (in_col_reg >= mdb_pkg::COL_W'(3))));
    assign out_last    = (out_col_reg == w_m1) && (out_row_reg == h_m1);

    // Window column fetched: the incoming pixel, or a virtual position past the frame
    assign fetch_col = operation ? fetch_col_reg : in_col_reg;
    assign fetch_row = operation ? fetch_row_reg : {1'b0, in_row_reg};

    // Position updates
    always_comb
    begin
        in_col_next    = in_col_reg;
        in_row_next    = in_row_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        fetch_col_next = fetch_col_reg;
        fetch_row_next = fetch_row_reg;

        out_col_inc = out_col_reg + 1'b1;
        out_row_inc = out_row_reg;
        if (out_col_reg == w_m1)
        begin
            out_col_inc = '0;
            out_row_inc = (out_row_reg == h_m1) ? '0 : out_row_reg + 1'b1;
        end

        if (geom_wr)
        begin
            in_col_next    = '0;
            in_row_next    = '0;
            out_col_next   = '0;
            out_row_next   = '0;
        end
        else if (shift)
        begin
            if (fetch_col == w_m1)
            begin
                fetch_col_next = '0;
                fetch_row_next = fetch_row + 1'b1;
            end
            else
            begin
                fetch_col_next = fetch_col + 1'b1;
                fetch_row_next = fetch_row;
            end
            if (!operation)
            begin
                if (in_col_reg == w_m1)
                begin
                    in_col_next = '0;
                    in_row_next = (in_row_reg == h_m1) ? '0 : in_row_reg + 1'b1;
                end
                else
                begin
                    in_col_next = in_col_reg + 1'b1;
                end
            end
            priority if (emit)
            begin
                out_col_next = out_col_inc;
                out_row_next = out_row_inc;
            end
            else if (draining)
            begin
                out_col_next = '0;
                out_row_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            fetch_col_reg <= '0;
            fetch_row_reg <= '0;
        end
        else
        begin
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            out_col_reg   <= out_col_next;
            out_row_reg   <= out_row_next;
            fetch_col_reg <= fetch_col_next;
            fetch_row_reg <= fetch_row_next;
        end
    end

    // Line store: one RAM per ring row, written at the input row, all read per column
    for (genvar s = 0; s < mdb_pkg::RING_ROWS; s++)
    begin : g_line
        mdb_ram #(
            .WIDTH (mdb_pkg::PIX_W),
            .DEPTH (mdb_pkg::MAX_WIDTH)
        ) u_line_ram (
            .clk     (clk),
            .wr_en   (accept && !operation &&
                      (mdb_pkg::SLOT_W'(in_row_reg) == mdb_pkg::SLOT_W'(s))),
            .wr_addr (in_col_reg),
            .wr_data ({red_in, green_in, blue_in}),
            .rd_en   (shift),
            .rd_addr (fetch_col),
            .rd_data (ram_rd[s])
        );
    end

    // Stage 1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= shift;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            s1_emit_reg <= emit;
            s1_done_reg <= out_last;
            s1_slot_reg <= mdb_pkg::SLOT_W'(fetch_row);
            s1_pix_reg  <= {red_in, green_in, blue_in};
            s1_cl_reg   <= mdb_pkg::sat3(mdb_pkg::DIM_W'(out_col_reg));
            s1_cr_reg   <= mdb_pkg::sat3(mdb_pkg::DIM_W'(w_m1 - out_col_reg));
            s1_rl_reg   <= mdb_pkg::sat3(mdb_pkg::DIM_W'(out_row_reg));
            s1_rr_reg   <= mdb_pkg::sat3(mdb_pkg::DIM_W'(h_m1 - out_row_reg));
        end
    end

    // New column: six stored rows above plus the incoming one; shift it in and
    // gather the reflected 7x7 window
    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            new_col[k] = ram_rd[mdb_pkg::SLOT_W'(s1_slot_reg + mdb_pkg::SLOT_W'(k + 2))];
        end
        new_col[6] = s1_pix_reg;
        for (int j = 0; j < 6; j++)
        begin
            new_line[j] = line_reg[j+1];
        end
        new_line[6] = new_col;
        for (int i = 0; i < mdb_pkg::TAPS; i++)
        begin
            for (int j = 0; j < mdb_pkg::TAPS; j++)
            begin
                win_next[i][j] = new_line[mdb_pkg::mirror_tap(j, s1_cl_reg, s1_cr_reg)]
                                         [mdb_pkg::mirror_tap(i, s1_rl_reg, s1_rr_reg)];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c2_reg <= '0;
        end
        else if (adv)
        begin
            c2_reg.valid <= s1_valid_reg & s1_emit_reg;
            c2_reg.done  <= s1_done_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg)
        begin
            line_reg <= new_line;
            if (s1_emit_reg)
            begin
                win_reg <= win_next;
            end
        end
    end

    // Blur and boost arithmetic
    mdb_kernel u_kernel (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .ctrl_in     (c2_reg),
        .win         (win_reg),
        .fine_gain   (fine_gain_reg),
        .coarse_gain (coarse_gain_reg),
        .ctrl_out    (k_out),
        .blue        (k_blue),
        .green       (k_green),
        .red         (k_red)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (adv && k_out.valid)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && k_out.valid)
        begin
            blue_reg       <= k_blue;
            green_reg      <= k_green;
            red_reg        <= k_red;
            frame_done_reg <= k_out.done;
        end
    end

    assign result_valid = result_valid_reg;
    assign blue_out     = blue_reg;
    assign green_out    = green_reg;
    assign red_out      = red_reg;
    assign frame_done   = frame_done_reg;

    // Checks
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !pixel_ready |-> (result_valid && !result_ready && k_out.valid))
        else $error("input stalled without a blocked result");

    a_in_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (in_row_reg <= h_m1) && (in_col_reg <= w_m1))
        else $error("input position outside the frame");

    a_out_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (out_row_reg <= h_m1) && (out_col_reg <= w_m1))
        else $error("output position outside the frame");

    a_idle_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation && !draining) |=> !s1_valid_reg)
        else $error("drain request with nothing pending entered the pipeline");

endmodule

FILE: test/tb_multiscale_detail_boost_filter_top.sv
`timescale 1ns / 100ps

// Predicts the boosted pixel stream and checks the results against it
class boost_scoreboard;
    typedef struct {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       last;
    } boost_pix_t;

    logic [23:0]     lines[8*2048];
    logic [23:0]     win[49];
    int unsigned     width_reg;
    int unsigned     height_reg;
    int unsigned     fine;
    int unsigned     coarse;
    int unsigned     col;
    int unsigned     row;
    int unsigned     out_pos;
    longint unsigned k3[3];
    longint unsigned k7[7];
    boost_pix_t      boosted_q[$];
    int              errors;
    int              checked;

    function new();
        longint unsigned s;
        k3[0] = (64'd294278940 + (64'd1 << 13)) >> 14;
        k3[2] = k3[0];
        k3[1] = (64'd1 << 16) - 2 * k3[0];
        k7[2] = (64'd204776330 + (64'd1 << 13)) >> 14;
        k7[1] = (64'd140740580 + (64'd1 << 13)) >> 14;
        k7[0] = (64'd75333008 + (64'd1 << 13)) >> 14;
        k7[4] = k7[2];
        k7[5] = k7[1];
        k7[6] = k7[0];
        s = k7[0] + k7[1] + k7[2];
        k7[3] = (64'd1 << 16) - 2 * s;
        width_reg = 640;
        height_reg = 480;
        fine = 24;
        coarse = 32;
        col = 0;
        row = 0;
        out_pos = 0;
        errors = 0;
        checked = 0;
    endfunction

    function int unsigned eff_w();
        return (width_reg < 4) ? 4 : (width_reg > 2048) ? 2048 : width_reg;
    endfunction

    function int unsigned eff_h();
        return (height_reg < 4) ? 4 : (height_reg > 2048) ? 2048 : height_reg;
    endfunction

    function void write_reg(mdb_pkg::reg_idx_t idx, int unsigned v);
        case (idx)
            mdb_pkg::REG_FRAME_WIDTH, mdb_pkg::REG_FRAME_HEIGHT:
            begin
                if (idx == mdb_pkg::REG_FRAME_WIDTH)
                    width_reg = v & 12'hfff;
                else
                    height_reg = v & 12'hfff;
                col = 0;
                row = 0;
                out_pos = 0;
            end
            mdb_pkg::REG_FINE_GAIN:   fine = v & 8'hff;
            mdb_pkg::REG_COARSE_GAIN: coarse = v & 8'hff;
            default: ;
        endcase
    endfunction

    function int mirror(int i, int n);
        if (i < 0)
            return -i;
        if (i > n - 1)
            return 2 * (n - 1) - i;
        return i;
    endfunction

    // Separable blur of one channel of the gathered window, rounded to Q.16
    function longint unsigned blur_ch(int rad, int sh);
        longint unsigned s;
        longint unsigned h;
        longint unsigned wi;
        longint unsigned wj;
        s = 0;
        for (int i = -rad; i <= rad; i++)
        begin
            h = 0;
            for (int j = -rad; j <= rad; j++)
            begin
                wj = (rad == 1) ? k3[j+1] : k7[j+3];
                h += wj * longint'((win[(i+3)*7 + j+3] >> sh) & 8'hff);
            end
            wi = (rad == 1) ? k3[i+1] : k7[i+3];
            s += wi * h;
        end
        return (s + (64'd1 << 15)) >> 16;
    endfunction

    function void push_boosted(int unsigned w, int unsigned h);
        int         r;
        int         c;
        longint     x;
        longint     b3;
        longint     b7;
        longint     t;
        logic [7:0] v[3];
        boost_pix_t e;
        r = out_pos / w;
        c = out_pos % w;
        for (int di = -3; di <= 3; di++)
            for (int dj = -3; dj <= 3; dj++)
                win[(di+3)*7 + dj+3] =
                    lines[(mirror(r + di, h) % 8) * 2048 + mirror(c + dj, w)];
        for (int ch = 0; ch < 3; ch++)
        begin
            x = (win[24] >> (8 * ch)) & 8'hff;
            b3 = blur_ch(1, 8 * ch);
            b7 = blur_ch(3, 8 * ch);
            t = x * (64'sd1 <<< 20) + longint'(fine) * (x * (64'sd1 <<< 16) - b3)
                + longint'(coarse) * (b3 - b7) + (64'sd1 <<< 19);
            if (t <= 0)
                v[ch] = 8'd0;
            else if ((t >>> 20) > 255)
                v[ch] = 8'd255;
            else
                v[ch] = 8'(t >>> 20);
        end
        e.blue = v[0];
        e.green = v[1];
        e.red = v[2];
        out_pos++;
        e.last = 1'b0;
        if (out_pos >= w * h)
        begin
            out_pos = 0;
            e.last = 1'b1;
        end
        boosted_q.push_back(e);
    endfunction

    function void note_request(logic op, logic [7:0] b, logic [7:0] g, logic [7:0] r);
        int unsigned w;
        int unsigned h;
        int unsigned p;
        bit          draining;
        w = eff_w();
        h = eff_h();
        draining = (row == 0 && col == 0 && out_pos != 0);
        if (op)
        begin
            if (draining)
                push_boosted(w, h);
            return;
        end
        // a pixel while results are pending starts a fresh frame
        if (draining)
            out_pos = 0;
        lines[(row % 8) * 2048 + col] = {r, g, b};
        p = row * w + col;
        col++;
        if (col >= w)
        begin
            col = 0;
            row++;
            if (row >= h)
                row = 0;
        end
        if (p >= 3 * w + 3)
            push_boosted(w, h);
    endfunction

    function void check_result(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic d);
        boost_pix_t e;
        if (boosted_q.size() == 0)
        begin
            $error("unexpected result %h %h %h %b", b, g, r, d);
            errors++;
            return;
        end
        e = boosted_q.pop_front();
        checked++;
        if (b !== e.blue)
        begin
            $error("blue_out expected %0d actual %0d", e.blue, b);
            errors++;
        end
        if (g !== e.green)
        begin
            $error("green_out expected %0d actual %0d", e.green, g);
            errors++;
        end
        if (r !== e.red)
        begin
            $error("red_out expected %0d actual %0d", e.red, r);
            errors++;
        end
        if (d !== e.last)
        begin
            $error("frame_done expected %0d actual %0d", e.last, d);
            errors++;
        end
    endfunction
endclass

module tb_multiscale_detail_boost_filter_top;

    logic                        clk;
    logic                        rst_n;
    logic                        pixel_valid;
    logic                        pixel_ready;
    logic                        operation;
    logic [7:0]                  blue_in;
    logic [7:0]                  green_in;
    logic [7:0]                  red_in;
    logic                        result_valid;
    logic                        result_ready;
    logic [7:0]                  blue_out;
    logic [7:0]                  green_out;
    logic [7:0]                  red_out;
    logic                        frame_done;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [mdb_pkg::PADDR_W-1:0] paddr;
    logic [mdb_pkg::PDATA_W-1:0] pwdata;
    logic [mdb_pkg::PDATA_W-1:0] prdata;
    logic                        pready;

    boost_scoreboard sb;
    int              sent;
    int              burst_left;
    int unsigned     stall_cnt;
    int              frames;

    multiscale_detail_boost_filter_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .operation    (operation),
        .blue_in      (blue_in),
        .green_in     (green_in),
        .red_in       (red_in),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .blue_out     (blue_out),
        .green_out    (green_out),
        .red_out      (red_out),
        .frame_done   (frame_done),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Receiver stalls: free-running stretches, then a ragged pattern
    always @(negedge clk)
    begin
        stall_cnt <= stall_cnt + 1;
        if ((stall_cnt % 300) < 80)
            result_ready <= 1'b1;
        else
            result_ready <= ((stall_cnt ^ (stall_cnt >> 3)) % 5) != 0;
    end

    // Result check
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            sb.check_result(blue_out, green_out, red_out, frame_done);
    end

    task automatic send_req(logic op, logic [7:0] b, logic [7:0] g, logic [7:0] r);
        int gap;
        // bursts of back-to-back requests with random gaps between them
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                pixel_valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        pixel_valid = 1'b1;
        operation = op;
        blue_in = b;
        green_in = g;
        red_in = r;
        do
            @(posedge clk);
        while (!pixel_ready);
        sb.note_request(op, b, g, r);
        sent++;
    endtask

    task automatic send_pixel_rand();
        send_req(1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic send_drains(int n);
        for (int i = 0; i < n; i++)
            send_req(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // Stop requests and let every pending result come out
    task automatic settle();
        @(negedge clk);
        pixel_valid = 1'b0;
        while (sb.boosted_q.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic reg_write(mdb_pkg::reg_idx_t idx, int unsigned v);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = mdb_pkg::PADDR_W'(4 * int'(idx));
        pwdata = v;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.write_reg(idx, v);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    function automatic int unsigned pick_gain();
        int k;
        k = $urandom_range(0, 9);
        return (k == 0) ? 0 : (k == 1) ? 255 : $urandom_range(0, 255);
    endfunction

    // Stimulus
    initial
    begin
        int w;
        int h;
        int n;
        int k;
        rst_n = 1'b0;
        pixel_valid = 1'b0;
        operation = 1'b0;
        blue_in = 8'd0;
        green_in = 8'd0;
        red_in = 8'd0;
        result_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        stall_cnt = 0;
        sent = 0;
        burst_left = 0;
        frames = 0;
        sb = new();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // drain with nothing to flush
        send_drains(1);
        settle();

        // smallest frame, maximum gains, checkerboard of extremes
        reg_write(mdb_pkg::REG_FRAME_WIDTH, 4);
        reg_write(mdb_pkg::REG_FRAME_HEIGHT, 4);
        reg_write(mdb_pkg::REG_FINE_GAIN, 255);
        reg_write(mdb_pkg::REG_COARSE_GAIN, 255);
        for (int i = 0; i < 16; i++)
        begin
            k = ((i + i / 4) % 2) ? 255 : 0;
            send_req(1'b0, 8'(k), 8'(255 - k), 8'(k));
        end
        send_drains(16);
        settle();

        // random frames, some flushed short or overflushed, stray drains too
        while (sent < 250)
        begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 9);
            h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 7);
            reg_write(mdb_pkg::REG_FRAME_WIDTH, w);
            reg_write(mdb_pkg::REG_FRAME_HEIGHT, h);
            reg_write(mdb_pkg::REG_FINE_GAIN, pick_gain());
            reg_write(mdb_pkg::REG_COARSE_GAIN, pick_gain());
            w = sb.eff_w();
            h = sb.eff_h();
            repeat ($urandom_range(1, 2))
            begin
                for (int i = 0; i < w * h; i++)
                begin
                    if ($urandom_range(0, 19) == 0 && i > 0)
                        send_drains(1);
                    send_pixel_rand();
                end
                k = $urandom_range(0, 9);
                n = 3 * w + 3;
                if (k == 0)
                    n = $urandom_range(0, n - 1);
                else if (k == 1)
                    n = n + $urandom_range(1, 3);
                send_drains(n);
                frames++;
            end
            settle();
        end

        // widest line, height clamped up from zero: a partial first line only
        reg_write(mdb_pkg::REG_FRAME_WIDTH, 4095);
        reg_write(mdb_pkg::REG_FRAME_HEIGHT, 0);
        reg_write(mdb_pkg::REG_FINE_GAIN, 24);
        reg_write(mdb_pkg::REG_COARSE_GAIN, 32);
        for (int i = 0; i < 20; i++)
            send_pixel_rand();
        settle();

        // tallest frame, partly sent, then restarted by a geometry write
        reg_write(mdb_pkg::REG_FRAME_WIDTH, 4);
        reg_write(mdb_pkg::REG_FRAME_HEIGHT, 4095);
        for (int i = 0; i < 60; i++)
            send_pixel_rand();
        settle();
        reg_write(mdb_pkg::REG_FRAME_HEIGHT, 4);
        for (int i = 0; i < 16; i++)
            send_pixel_rand();
        send_drains(15);
        settle();

        $display("Run sent %0d requests over %0d random frames plus edge geometries,",
                 sent, frames);
        $display("and checked %0d boosted pixels.", sb.checked);
        if (sb.errors == 0 && sb.boosted_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule

FILE: filelist.f
hdl/mdb_pkg.sv
hdl/mdb_ram.sv
hdl/mdb_kernel.sv
hdl/multiscale_detail_boost_filter_top.sv
test/tb_multiscale_detail_boost_filter_top.sv
